/* rtl/c_string_literal_escaper_macros.svh */
// Assertion macros for the C string literal escaper checker.
// Needs clk and rst_n in the scope of each use.
`ifndef C_STRING_LITERAL_ESCAPER_MACROS_SVH
`define C_STRING_LITERAL_ESCAPER_MACROS_SVH

// Checked only while out of reset.
`define CSLESC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset cycles included.
`define CSLESC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cslesc_pkg.sv */
// Shared types, character constants and the byte escape table function.
// No dependencies.
`timescale 1ns / 1ps

package cslesc_pkg;

  localparam int MaxChars  = 9;
  localparam int CharIdxW  = 4;
  localparam logic [7:0] CtrlLimit = 8'd32;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChBslash  = 8'h5c;
  localparam logic       CmdData   = 1'b0;
  localparam logic       CmdEnd    = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } out_item_t;

  // Characters caused by one accepted item, in output order from index 0.
  typedef struct packed {
    logic [CharIdxW-1:0]       len;
    logic [MaxChars-1:0][7:0]  chars;
  } plan_t;

  // Escaped form of one nonzero data byte: one, two or four characters.
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] chars;
  } esc_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  function automatic esc_t esc_byte(input logic [7:0] b);
    esc_t       e;
    logic [7:0] pair;
    logic       is_pair;
    e       = '0;
    pair    = '0;
    is_pair = 1'b1;
    case (b)
      8'h0d:   pair = 8'h72; // r
      8'h0a:   pair = 8'h6e; // n
      8'h22:   pair = 8'h22;
      8'h5c:   pair = 8'h5c;
      8'h27:   pair = 8'h27;
      8'h07:   pair = 8'h61; // a
      8'h08:   pair = 8'h62; // b
      8'h0c:   pair = 8'h66; // f
      8'h09:   pair = 8'h74; // t
      8'h0b:   pair = 8'h76; // v
      default: is_pair = 1'b0;
    endcase
    if (is_pair) begin
      e.len      = 3'd2;
      e.chars[0] = ChBslash;
      e.chars[1] = pair;
    end else if (b < CtrlLimit) begin
      // octal: byte is below 32, so the high digit is bits 4:3
      e.len      = 3'd4;
      e.chars[0] = ChBslash;
      e.chars[1] = ChZero;
      e.chars[2] = ChZero + {6'd0, b[4:3]};
      e.chars[3] = ChZero + {5'd0, b[2:0]};
    end else begin
      e.len      = 3'd1;
      e.chars[0] = b;
    end
    return e;
  endfunction

endpackage

/* rtl/cslesc_front.sv */
// Front part: accepts items, tracks string and pending NUL state, builds
// the character plan for each item. Depends on cslesc_pkg.
`timescale 1ns / 1ps

module cslesc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  cslesc_pkg::in_item_t in_data,
  input  cslesc_pkg::q_stat_t q_stat,
  output logic                q_push,
  output cslesc_pkg::plan_t   q_plan
);
  import cslesc_pkg::*;

  logic            inside_r, inside_nxt;
  logic            held_r, held_nxt;
  logic            accept;
  logic            open_q;
  logic            digit;
  logic [2:0]      nul_len;
  logic [2:0]      body_len;
  logic [3:0][7:0] body;
  esc_t            esc;
  logic [CharIdxW-1:0] k;
  logic [CharIdxW-1:0] m;

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;
  assign open_q  = !inside_r;
  assign digit   = (in_data.data_byte >= ChZero) && (in_data.data_byte <= ChNine);
  assign esc     = esc_byte(in_data.data_byte);

  always_comb begin
    inside_nxt = inside_r;
    held_nxt   = held_r;
    nul_len    = 3'd0;
    body_len   = 3'd0;
    body       = '0;
    if (in_data.command == CmdEnd) begin
      if (held_r) nul_len = 3'd2;
      body_len = 3'd1;
      body[0]  = ChQuote;
    end else begin
      if (held_r) nul_len = digit ? 3'd4 : 3'd2;
      if (in_data.data_byte != 8'd0) begin
        body_len = esc.len;
        body     = esc.chars;
      end
    end
    if (accept) begin
      inside_nxt = (in_data.command == CmdData);
      held_nxt   = (in_data.command == CmdData) && (in_data.data_byte == 8'd0);
    end
  end

  // Lay out opening quote, NUL escape and body side by side.
  always_comb begin
    q_plan     = '0;
    q_plan.len = CharIdxW'({3'd0, open_q}) + CharIdxW'(nul_len) + CharIdxW'(body_len);
    k          = '0;
    m          = '0;
    for (int p = 0; p < MaxChars; p++) begin
      k = CharIdxW'(p) - CharIdxW'({3'd0, open_q});
      m = k - CharIdxW'(nul_len);
      if (open_q && p == 0) begin
        q_plan.chars[p] = ChQuote;
      end else if (k < CharIdxW'(nul_len)) begin
        q_plan.chars[p] = (k == '0) ? ChBslash : ChZero;
      end else if (m < CharIdxW'(4)) begin
        q_plan.chars[p] = body[m[1:0]];
      end else begin
        q_plan.chars[p] = 8'd0;
      end
    end
  end

  // A NUL held inside an open string causes nothing yet: skip the queue.
  assign q_push = accept && (q_plan.len != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      held_r   <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule

/* rtl/cslesc_fifo.sv */
// Short plan queue between front and back parts.
// Depends on cslesc_pkg.
`timescale 1ns / 1ps

module cslesc_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cslesc_pkg::plan_t   push_plan,
  input  logic                pop,
  output cslesc_pkg::plan_t   head,
  output cslesc_pkg::q_stat_t stat
);
  import cslesc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  plan_t            mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CntW'(DEPTH));
  assign stat.valid = (cnt_r != '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_plan;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/cslesc_back.sv */
// Back part: walks the head plan one character a cycle into the result
// register while that is free or being drained. Depends on cslesc_pkg.
`timescale 1ns / 1ps

module cslesc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cslesc_pkg::plan_t    head,
  input  cslesc_pkg::q_stat_t  q_stat,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output cslesc_pkg::out_item_t out_data
);
  import cslesc_pkg::*;

  logic [CharIdxW-1:0] idx_r, idx_nxt;
  logic                ovalid_r, ovalid_nxt;
  out_item_t           odata_r;
  logic                adv;
  logic                last;

  // Load when the result register is free or being drained this cycle.
  assign adv       = q_stat.valid && (!ovalid_r || out_pop);
  assign last      = (idx_r == head.len - 1'b1);
  assign q_pop     = adv && last;
  assign out_empty = !ovalid_r;
  assign out_data  = odata_r;

  always_comb begin
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    if (adv) begin
      idx_nxt    = last ? '0 : idx_r + 1'b1;
      ovalid_nxt = 1'b1;
    end else if (out_pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      odata_r.out_char <= head.chars[idx_r];
      odata_r.run_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

/* rtl/c_string_literal_escaper.sv */
// Top level of the C string literal escaper: front, plan queue, back.
// Depends on cslesc_pkg, cslesc_front, cslesc_fifo, cslesc_back.
//
//  channel | ports                      | moves
//  --------+----------------------------+----------------------------------
//  input   | in_push, in_full, in_data  | command / data byte, one a request
//  result  | out_pop, out_empty, out_data | one literal character a request
//
// The front turns each accepted item into a plan of 0 to 6 characters,
// registered in the plan queue; the back moves it one character a cycle
// into the result register while that is free or drained, so plain bytes
// stream at one per cycle while out_pop stays high.
// Reset is synchronous: it closes any open string, drops a pending NUL and
// empties the queue and result register. in_full rises while the plan queue
// holds QUEUE_DEPTH plans; a stalled result holds on out_data.
`timescale 1ns / 1ps

module c_string_literal_escaper #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  cslesc_pkg::in_item_t  in_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output cslesc_pkg::out_item_t out_data
);
  import cslesc_pkg::*;

  q_stat_t q_stat;
  plan_t   q_plan;
  plan_t   q_head;
  logic    q_push;
  logic    q_pop;

  cslesc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_plan  (q_plan)
  );

  cslesc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_plan (q_plan),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  cslesc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

/* rtl/cslesc_chk.sv */
// Port-level checker for the C string literal escaper, bound to the top.
// Depends on cslesc_pkg and c_string_literal_escaper_macros.svh.
`timescale 1ns / 1ps
`include "c_string_literal_escaper_macros.svh"

module cslesc_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_push,
  input logic                  in_full,
  input cslesc_pkg::in_item_t  in_data,
  input logic                  out_empty,
  input logic                  out_pop,
  input cslesc_pkg::out_item_t out_data
);
  import cslesc_pkg::*;

  // Reset empties the result side and frees the input side.
  `CSLESC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> out_empty, "result not empty after reset")
  `CSLESC_ASSERT_ALWAYS(a_rst_free, !rst_n |=> !in_full, "input full after reset")
  // Bytes below 32, NUL included, never leave unescaped.
  `CSLESC_ASSERT(a_no_ctrl, !out_empty |-> (out_data.out_char >= CtrlLimit), "raw control char")
  // Hold a stalled result.
  `CSLESC_ASSERT(a_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)), "result dropped")

endmodule

bind c_string_literal_escaper cslesc_chk u_chk (.*);

/* bench/c_string_literal_escaper_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for c_string_literal_escaper: directed requests, then random strings.
// Depends on cslesc_pkg and the c_string_literal_escaper RTL.

module c_string_literal_escaper_test;
  import cslesc_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int TailCycles    = 12;
  localparam int RandomItems   = 405;

  // Typed-in expectation for one request; typed = 0 leaves it to the predictor.
  typedef struct packed {
    logic            typed;
    logic [3:0]      len;
    logic [5:0][7:0] txt;
  } hint_t;

  typedef struct packed {
    in_item_t req;
    hint_t    hint;
  } row_t;

  localparam hint_t Free = '0;

  localparam row_t Directed [26] = '{
    '{'{CmdEnd,  8'h00}, '{1'b1, 4'd2, "\"\""}},
    '{'{CmdData, 8'h41}, '{1'b1, 4'd2, "\"A"}},
    '{'{CmdData, 8'hff}, Free},
    '{'{CmdData, 8'h0d}, '{1'b1, 4'd2, "\\r"}},
    '{'{CmdData, 8'h0a}, '{1'b1, 4'd2, "\\n"}},
    '{'{CmdData, 8'h22}, '{1'b1, 4'd2, "\\\""}},
    '{'{CmdData, 8'h5c}, '{1'b1, 4'd2, "\\\\"}},
    '{'{CmdData, 8'h27}, '{1'b1, 4'd2, "\\'"}},
    '{'{CmdData, 8'h07}, '{1'b1, 4'd2, "\\a"}},
    '{'{CmdData, 8'h08}, '{1'b1, 4'd2, "\\b"}},
    '{'{CmdData, 8'h0c}, '{1'b1, 4'd2, "\\f"}},
    '{'{CmdData, 8'h09}, '{1'b1, 4'd2, "\\t"}},
    '{'{CmdData, 8'h0b}, '{1'b1, 4'd2, "\\v"}},
    '{'{CmdData, 8'h01}, '{1'b1, 4'd4, "\\001"}},
    '{'{CmdData, 8'h1f}, '{1'b1, 4'd4, "\\037"}},
    '{'{CmdData, 8'h00}, '{1'b1, 4'd0, ""}},
    '{'{CmdData, 8'h30}, '{1'b1, 4'd5, "\\0000"}},
    '{'{CmdData, 8'h00}, '{1'b1, 4'd0, ""}},
    '{'{CmdData, 8'h41}, '{1'b1, 4'd3, "\\0A"}},
    '{'{CmdData, 8'h00}, '{1'b1, 4'd0, ""}},
    '{'{CmdEnd,  8'hff}, '{1'b1, 4'd3, "\\0\""}},
    '{'{CmdData, 8'h00}, '{1'b1, 4'd1, "\""}},
    '{'{CmdData, 8'h39}, '{1'b1, 4'd5, "\\0009"}},
    '{'{CmdData, 8'h00}, '{1'b1, 4'd0, ""}},
    '{'{CmdData, 8'h1e}, '{1'b1, 4'd6, "\\0\\036"}},
    '{'{CmdEnd,  8'h5a}, '{1'b1, 4'd1, "\""}}
  };

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_data = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_data;

  // Predictor state: string open, NUL pending.
  logic      open_str    = 1'b0;
  logic      nul_pending = 1'b0;
  out_item_t lit_chars[$];
  hint_t     hint_q[$];
  out_item_t want;

  int errors        = 0;
  int sent          = 0;
  int idle_run      = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  c_string_literal_escaper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] exp_val);
    $display("%0t: %s: got %h, expected %h", $time, what, got, exp_val);
    errors++;
  endtask

  function automatic void predict_literal(input in_item_t req, input hint_t hint);
    logic [7:0] chars[$];
    logic [7:0] b;
    logic [7:0] pair;
    out_item_t  o;
    b    = req.data_byte;
    pair = '0;
    if (!open_str) begin
      chars = {chars, ChQuote};
      open_str = 1'b1;
    end
    if (req.command == CmdEnd) begin
      if (nul_pending) begin
        chars = {chars, ChBslash, ChZero};
      end
      chars = {chars, ChQuote};
      open_str    = 1'b0;
      nul_pending = 1'b0;
    end else begin
      // a pending NUL widens to three digits when a digit follows
      if (nul_pending) begin
        chars = {chars, ChBslash, ChZero};
        if (b >= ChZero && b <= ChNine) begin
          chars = {chars, ChZero, ChZero};
        end
        nul_pending = 1'b0;
      end
      case (b)
        8'h0d:   pair = "r";
        8'h0a:   pair = "n";
        8'h22:   pair = ChQuote;
        8'h5c:   pair = ChBslash;
        8'h27:   pair = "'";
        8'h07:   pair = "a";
        8'h08:   pair = "b";
        8'h0c:   pair = "f";
        8'h09:   pair = "t";
        8'h0b:   pair = "v";
        default: pair = '0;
      endcase
      if (b == 8'h00) begin
        nul_pending = 1'b1;
      end else if (pair != 8'h00) begin
        chars = {chars, ChBslash, pair};
      end else if (b < CtrlLimit) begin
        chars = {chars, ChBslash, ChZero};
        chars = {chars, ChZero + (b >> 3), ChZero + {5'd0, b[2:0]}};
      end else begin
        chars = {chars, b};
      end
    end
    if (hint.typed) begin
      chars.delete();
      for (int i = 0; i < hint.len; i++) chars = {chars, hint.txt[hint.len - 1 - i]};
    end
    foreach (chars[i]) begin
      o.out_char = chars[i];
      o.run_last = (i == chars.size() - 1);
      lit_chars = {lit_chars, o};
    end
  endfunction

  // Sample both channels at the edge; predict on input, compare on output.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) predict_literal(in_data, hint_q.pop_front());
      if (out_pop && !out_empty) begin
        if (lit_chars.size() == 0) begin
          report("unexpected char", out_data.out_char, 8'h00);
        end else begin
          want = lit_chars.pop_front();
          if (out_data.out_char != want.out_char)
            report("out_char", out_data.out_char, want.out_char);
          if (out_data.run_last != want.run_last)
            report("run_last", {7'd0, out_data.run_last}, {7'd0, want.run_last});
        end
      end
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_run = 0;
      else idle_run++;
    end
  end

  always @(posedge clk) out_pop <= ($urandom_range(99) >= recv_idle_pct);

  initial begin
    wait (idle_run >= WatchdogLimit);
    $display("c_string_literal_escaper: mismatch");
    $finish;
  end

  // Hold push high from one request to the next; drop it only to idle.
  task automatic offer(input in_item_t req, input hint_t hint);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    hint_q = {hint_q, hint};
    in_push <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sent++;
  endtask

  // Drop push, then wait for every expected char.
  task automatic wait_idle();
    in_push <= 1'b0;
    do @(posedge clk); while (lit_chars.size() != 0 || hint_q.size() != 0);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'h00;
    if (r < 30) return ChZero + 8'($urandom_range(9));
    if (r < 45) return 8'($urandom_range(31));
    if (r < 55) begin
      case ($urandom_range(2))
        0:       return ChQuote;
        1:       return ChBslash;
        default: return 8'h27;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // Mostly whole strings with random content, some stray requests between them; drains once halfway.
  task automatic run_phase(input int n_items);
    in_item_t req;
    int       stop_at;
    int       len;
    bit       paused;
    stop_at = sent + n_items;
    paused  = 1'b0;
    while (sent < stop_at) begin
      if (!paused && sent >= stop_at - n_items / 2) begin
        wait_idle();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 8) begin
        req.command   = 1'($urandom_range(1));
        req.data_byte = 8'($urandom_range(255));
        offer(req, Free);
      end else begin
        len = $urandom_range(10);
        repeat (len) begin
          req.command   = CmdData;
          req.data_byte = pick_byte();
          offer(req, Free);
        end
        req.command   = CmdEnd;
        req.data_byte = 8'($urandom_range(255));
        offer(req, Free);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (Directed[i]) offer(Directed[i].req, Directed[i].hint);
    send_idle_pct = 20;
    recv_idle_pct = 45;
    run_phase(RandomItems / 3);
    send_idle_pct = 45;
    recv_idle_pct = 20;
    run_phase(RandomItems / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(RandomItems / 3);
    wait_idle();
    repeat (TailCycles) @(posedge clk);
    if (lit_chars.size() != 0) report("chars never delivered", 8'h00, lit_chars[0].out_char);
    if (errors == 0) begin
      $display("c_string_literal_escaper: match");
    end else begin
      $display("c_string_literal_escaper: mismatch");
    end
    $finish;
  end

endmodule
